### src/lss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_pkg: shared types and constants for the lidar sector steering block
// payload structs, config struct, controller/datapath command and status
// ----------------------------------------------------------------------------
package lss_pkg;

  // one range sample of a scan
  typedef struct packed {
    logic [15:0] range_mm;
    logic [11:0] sample_index;
    logic        last_sample;
  } sample_t;

  // one steering command
  typedef struct packed {
    logic signed [31:0] angular_rate;
    logic signed [15:0] linear_rate;
    logic               stopped;
  } steer_t;

  // configuration register contents
  typedef struct packed {
    logic [15:0]        angle_coef;
    logic signed [15:0] forward_speed;
    logic [12:0]        samples_per_scan;
    logic [15:0]        valid_floor_mm;
    logic [15:0]        stop_distance_mm;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic take;      // sample transaction this cycle
    logic calc;      // form sector minima, clear scan state
    logic mul;       // coefficient times difference
    logic div_step;  // one quotient bit
    logic load;      // write the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;  // output register full and not being taken
  } status_t;

  // register map, index = paddr[4:2]
  localparam logic [2:0] REG_ANGLE_COEF    = 3'd0;
  localparam logic [2:0] REG_FORWARD_SPEED = 3'd1;
  localparam logic [2:0] REG_SAMPLES       = 3'd2;
  localparam logic [2:0] REG_VALID_FLOOR   = 3'd3;
  localparam logic [2:0] REG_STOP_DIST     = 3'd4;

  localparam logic [15:0] RST_ANGLE_COEF  = 16'd256;
  localparam logic [15:0] RST_FWD_SPEED   = 16'd0;
  localparam logic [12:0] RST_SAMPLES     = 13'd360;
  localparam logic [15:0] RST_VALID_FLOOR = 16'd50;
  localparam logic [15:0] RST_STOP_DIST   = 16'd400;

  localparam int          DEG_PER_SCAN = 360;
  localparam logic [12:0] FRONT_LO_DEG = 13'd150;
  localparam logic [12:0] FRONT_HI_DEG = 13'd210;
  localparam int          MAX_DEG      = 8191 / DEG_PER_SCAN;

  localparam int          DIV_STEPS = 32;
  localparam logic [31:0] SAT_MAG   = 32'h7FFF_FFFF;
  localparam logic [15:0] RANGE_MAX = 16'hFFFF;

endpackage

### src/lss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_ctrl: sequencer for the lidar sector steering block
// streams samples in idle, then runs multiply and bit-serial divide per scan
// ----------------------------------------------------------------------------
module lss_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  input  logic             last_sample,
  output logic             sample_ready,
  input  lss_pkg::status_t status,
  output lss_pkg::cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CALC = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  localparam int CW = $clog2(lss_pkg::DIV_STEPS);
  localparam logic [CW-1:0] CNT_LAST = CW'(lss_pkg::DIV_STEPS - 1);

  state_t        state, state_next;
  logic [CW-1:0] cnt;

  assign sample_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.take     = sample_valid && sample_ready;
    cmd.calc     = (state == S_CALC);
    cmd.mul      = (state == S_MUL);
    cmd.div_step = (state == S_DIV);
    cmd.load     = (state == S_FIN) && !status.out_busy;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (cmd.take && last_sample) state_next = S_CALC;
      S_CALC: state_next = S_MUL;
      S_MUL:  state_next = S_DIV;
      S_DIV:  if (cnt == CNT_LAST) state_next = S_FIN;
      S_FIN:  if (!status.out_busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == S_MUL) cnt <= '0;
      else if (state == S_DIV) cnt <= cnt + CW'(1);
    end
  end

  a_last_starts_calc: assert property (@(posedge clk) disable iff (rst)
    cmd.take && last_sample |=> state == S_CALC)
    else $error("last sample did not start the end-of-scan sequence");

  a_div_length: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && cnt == CNT_LAST |=> state == S_FIN)
    else $error("divide did not end after its last step");

  a_div_count_start: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |=> state == S_DIV && cnt == '0)
    else $error("divide step count not cleared");

endmodule

### src/lss_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_datapath: sector minima, multiply, restoring divider, output register
// ----------------------------------------------------------------------------
module lss_datapath #(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  lss_pkg::cfg_t    cfg,
  input  lss_pkg::cmd_t    cmd,
  input  lss_pkg::sample_t sample,
  output lss_pkg::status_t status,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output lss_pkg::steer_t  steer
);

  // sector bounds
  logic [12:0] n, quarter, half, left_end, front_lo, front_hi, idx;
  logic [4:0]  deg;

  always_comb begin
    if (int'(cfg.samples_per_scan) > MAX_SAMPLES) n = 13'(MAX_SAMPLES);
    else n = cfg.samples_per_scan;
    quarter  = n >> 2;
    half     = n >> 1;
    left_end = quarter + (quarter << 1);
    // n / 360 by threshold count
    deg = '0;
    for (int k = 1; k <= lss_pkg::MAX_DEG; k++) begin
      if (n >= 13'(k * lss_pkg::DEG_PER_SCAN)) deg = deg + 5'd1;
    end
    front_lo = 13'({8'd0, deg} * lss_pkg::FRONT_LO_DEG);
    front_hi = 13'({8'd0, deg} * lss_pkg::FRONT_HI_DEG);
    idx      = {1'b0, sample.sample_index};
  end

  logic [15:0] right_min, left_min, front_min, first_val, mid_val;
  logic [15:0] r_w, l_w, f_w;
  logic        valid_w;

  assign valid_w = sample.range_mm > cfg.valid_floor_mm;
  assign r_w = (right_min < mid_val)   ? right_min : mid_val;
  assign l_w = (left_min  < first_val) ? left_min  : first_val;
  assign f_w = (front_min < first_val) ? front_min : first_val;

  always_ff @(posedge clk) begin
    if (rst || cmd.calc) begin
      right_min <= lss_pkg::RANGE_MAX;
      left_min  <= lss_pkg::RANGE_MAX;
      front_min <= lss_pkg::RANGE_MAX;
      first_val <= lss_pkg::RANGE_MAX;
      mid_val   <= lss_pkg::RANGE_MAX;
    end else if (cmd.take) begin
      if (idx == '0)   first_val <= sample.range_mm;
      if (idx == half) mid_val   <= sample.range_mm;
      if (valid_w) begin
        if (idx >= quarter && idx < half && sample.range_mm < right_min)
          right_min <= sample.range_mm;
        if (idx >= half && idx < left_end && sample.range_mm < left_min)
          left_min <= sample.range_mm;
        if (idx >= front_lo && idx < front_hi && sample.range_mm < front_min)
          front_min <= sample.range_mm;
      end
    end
  end

  // end-of-scan arithmetic
  logic [15:0] diff_q, div_q, rem;
  logic        neg_q, stop_q, diff_zero_q, div_zero_q;
  logic [31:0] quo;
  logic [16:0] trial;
  logic        fits;

  assign trial = {rem, quo[31]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      neg_q       <= l_w >= r_w;
      diff_q      <= (l_w >= r_w) ? (l_w - r_w) : (r_w - l_w);
      div_q       <= (l_w >= r_w) ? r_w : l_w;
      diff_zero_q <= l_w == r_w;
      div_zero_q  <= ((l_w >= r_w) ? r_w : l_w) == '0;
      stop_q      <= f_w < cfg.stop_distance_mm;
    end
    if (cmd.mul) begin
      quo <= {16'd0, cfg.angle_coef} * {16'd0, diff_q};
      rem <= '0;
    end else if (cmd.div_step) begin
      rem <= fits ? 16'(trial - {1'b0, div_q}) : trial[15:0];
      quo <= {quo[30:0], fits};
    end
  end

  logic [31:0] mag;
  always_comb begin
    if (diff_zero_q) mag = '0;
    else if (div_zero_q || quo[31]) mag = lss_pkg::SAT_MAG;
    else mag = quo;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (cmd.load) begin
      cmd_valid <= 1'b1;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (stop_q) begin
        steer.angular_rate <= '0;
        steer.linear_rate  <= '0;
        steer.stopped      <= 1'b1;
      end else begin
        steer.angular_rate <= neg_q ? -$signed(mag) : $signed(mag);
        steer.linear_rate  <= cfg.forward_speed;
        steer.stopped      <= 1'b0;
      end
    end
  end

  assign status.out_busy = cmd_valid && !cmd_ready;

  a_scan_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.calc |=> right_min == lss_pkg::RANGE_MAX && left_min == lss_pkg::RANGE_MAX
                 && front_min == lss_pkg::RANGE_MAX && first_val == lss_pkg::RANGE_MAX
                 && mid_val == lss_pkg::RANGE_MAX)
    else $error("scan state not cleared after end of scan");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !cmd_valid || cmd_ready)
    else $error("output register overwritten before it was taken");

  a_equal_sides: assert property (@(posedge clk) disable iff (rst)
    cmd.load && diff_zero_q |=> steer.angular_rate == '0)
    else $error("equal sides gave a nonzero turn");

endmodule

### src/lidar_sector_steering.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_sector_steering: reactive steering from one lidar scan
// tracks per-sector range minima and emits one turn/speed command per scan
// ----------------------------------------------------------------------------
// usage
//   sample channel (sample_valid/sample_ready/sample): one range sample per
//   transaction, with its index and a last-of-scan mark
//   cmd channel (cmd_valid/cmd_ready/cmd): one steering command per scan
//   apb port: five config registers at 4*i, write while the block is idle
// timing
//   ordinary samples are taken one per cycle while the block is idle
//   a last sample starts the end-of-scan sequence: the calc state forms the
//   minima, the mul state does the coefficient multiply, the div state runs
//   the one-bit-per-cycle restoring divider, and the fin state loads the
//   output register once it is not busy; sample_ready is low from the last
//   sample transaction until that load
// reset
//   rst is synchronous; registers return to their defaults, the minima to
//   all ones, the output register empties
// stall
//   a waiting command sits in the output register while the next scan
//   streams in; only the end of that scan waits for cmd_ready
// ----------------------------------------------------------------------------
module lidar_sector_steering #(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic             clk,
  input  logic             rst,
  // sample stream
  input  logic             sample_valid,
  output logic             sample_ready,
  input  lss_pkg::sample_t sample,
  // steering commands
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output lss_pkg::steer_t  cmd,
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  lss_pkg::cfg_t    cfg;
  lss_pkg::cmd_t    dp_cmd;
  lss_pkg::status_t dp_status;
  logic             wr_en;
  logic [2:0]       reg_idx;

  // apb: zero wait states, write on the access phase
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_coef       <= lss_pkg::RST_ANGLE_COEF;
      cfg.forward_speed    <= lss_pkg::RST_FWD_SPEED;
      cfg.samples_per_scan <= lss_pkg::RST_SAMPLES;
      cfg.valid_floor_mm   <= lss_pkg::RST_VALID_FLOOR;
      cfg.stop_distance_mm <= lss_pkg::RST_STOP_DIST;
    end else if (wr_en) begin
      case (reg_idx)
        lss_pkg::REG_ANGLE_COEF:    cfg.angle_coef       <= pwdata[15:0];
        lss_pkg::REG_FORWARD_SPEED: cfg.forward_speed    <= pwdata[15:0];
        lss_pkg::REG_SAMPLES:       cfg.samples_per_scan <= pwdata[12:0];
        lss_pkg::REG_VALID_FLOOR:   cfg.valid_floor_mm   <= pwdata[15:0];
        lss_pkg::REG_STOP_DIST:     cfg.stop_distance_mm <= pwdata[15:0];
        default: ;  // unmapped addresses ignore writes
      endcase
    end
  end

  // read mux, zero extended
  always_comb begin
    case (reg_idx)
      lss_pkg::REG_ANGLE_COEF:    prdata = {16'd0, cfg.angle_coef};
      lss_pkg::REG_FORWARD_SPEED: prdata = {16'd0, cfg.forward_speed};
      lss_pkg::REG_SAMPLES:       prdata = {19'd0, cfg.samples_per_scan};
      lss_pkg::REG_VALID_FLOOR:   prdata = {16'd0, cfg.valid_floor_mm};
      lss_pkg::REG_STOP_DIST:     prdata = {16'd0, cfg.stop_distance_mm};
      default:                    prdata = '0;
    endcase
  end

  // sequencer
  lss_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .last_sample  (sample.last_sample),
    .sample_ready (sample_ready),
    .status       (dp_status),
    .cmd          (dp_cmd)
  );

  // minima, multiply/divide, output register
  lss_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (dp_cmd),
    .sample    (sample),
    .status    (dp_status),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .steer     (cmd)
  );

endmodule

### sim/lss_steer_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_steer_check: command checker for lidar_sector_steering
// follows config writes and sample transactions, keeps its own sector minima,
// and compares every steering command with the oldest one it worked out
// ----------------------------------------------------------------------------
module lss_steer_check #(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  input  logic             sample_ready,
  input  lss_pkg::sample_t sample,
  input  logic             cmd_valid,
  input  logic             cmd_ready,
  input  lss_pkg::steer_t  cmd,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  input  logic             pready,
  output int               mismatches,
  output int               pending
);

  lss_pkg::cfg_t   cfg_q;
  logic [15:0]     right_min = lss_pkg::RANGE_MAX;
  logic [15:0]     left_min  = lss_pkg::RANGE_MAX;
  logic [15:0]     front_min = lss_pkg::RANGE_MAX;
  logic [15:0]     first_val = lss_pkg::RANGE_MAX;
  logic [15:0]     mid_val   = lss_pkg::RANGE_MAX;
  lss_pkg::steer_t steer_due[$];
  int              due_count  = 0;
  int              fail_total = 0;

  assign mismatches = fail_total;
  assign pending    = due_count;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    fail_total++;
  endtask

  function automatic logic [15:0] min16(input logic [15:0] a, input logic [15:0] b);
    return (a < b) ? a : b;
  endfunction

  // coef * diff / div, truncated, saturated to 31 bits
  function automatic logic [31:0] steer_magnitude(input logic [15:0] diff,
                                                  input logic [15:0] div);
    logic [63:0] q;
    if (diff == 16'd0) return 32'd0;
    if (div == 16'd0) return lss_pkg::SAT_MAG;
    q = (64'(cfg_q.angle_coef) * 64'(diff)) / 64'(div);
    if (q > 64'(lss_pkg::SAT_MAG)) q = 64'(lss_pkg::SAT_MAG);
    return q[31:0];
  endfunction

  task automatic clear_scan();
    right_min = lss_pkg::RANGE_MAX;
    left_min  = lss_pkg::RANGE_MAX;
    front_min = lss_pkg::RANGE_MAX;
    first_val = lss_pkg::RANGE_MAX;
    mid_val   = lss_pkg::RANGE_MAX;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    case (idx)
      lss_pkg::REG_ANGLE_COEF:    cfg_q.angle_coef       = data[15:0];
      lss_pkg::REG_FORWARD_SPEED: cfg_q.forward_speed    = data[15:0];
      lss_pkg::REG_SAMPLES:       cfg_q.samples_per_scan = data[12:0];
      lss_pkg::REG_VALID_FLOOR:   cfg_q.valid_floor_mm   = data[15:0];
      lss_pkg::REG_STOP_DIST:     cfg_q.stop_distance_mm = data[15:0];
      default: ;
    endcase
  endtask

  task automatic take_sample(input lss_pkg::sample_t s);
    int unsigned     n, quarter, half, deg, idx;
    logic [15:0]     r, l, f;
    logic [31:0]     mag;
    lss_pkg::steer_t want;
    n = (cfg_q.samples_per_scan > MAX_SAMPLES) ? MAX_SAMPLES : cfg_q.samples_per_scan;
    quarter = n / 4;
    half    = n / 2;
    deg     = n / lss_pkg::DEG_PER_SCAN;
    idx     = s.sample_index;
    if (idx == 0) first_val = s.range_mm;
    if (idx == half) mid_val = s.range_mm;
    if (s.range_mm > cfg_q.valid_floor_mm) begin
      if (idx >= quarter && idx < half) right_min = min16(right_min, s.range_mm);
      if (idx >= half && idx < quarter * 3) left_min = min16(left_min, s.range_mm);
      if (idx >= deg * lss_pkg::FRONT_LO_DEG && idx < deg * lss_pkg::FRONT_HI_DEG)
        front_min = min16(front_min, s.range_mm);
    end
    if (s.last_sample) begin
      r = min16(right_min, mid_val);
      l = min16(left_min, first_val);
      f = min16(front_min, first_val);
      // turn away from the nearer side
      if (l >= r) begin
        mag = steer_magnitude(l - r, r);
        want.angular_rate = 32'd0 - mag;
      end else begin
        mag = steer_magnitude(r - l, l);
        want.angular_rate = mag;
      end
      if (f < cfg_q.stop_distance_mm) begin
        want.angular_rate = '0;
        want.linear_rate  = '0;
        want.stopped      = 1'b1;
      end else begin
        want.linear_rate = cfg_q.forward_speed;
        want.stopped     = 1'b0;
      end
      steer_due.push_back(want);
      clear_scan();
    end
  endtask

  task automatic check_cmd(input lss_pkg::steer_t got);
    lss_pkg::steer_t want;
    if (steer_due.size() == 0) begin
      report_mismatch("command with no scan ended", got.angular_rate, 32'd0);
    end else begin
      want = steer_due.pop_front();
      if (got.angular_rate !== want.angular_rate)
        report_mismatch("angular_rate", got.angular_rate, want.angular_rate);
      if (got.linear_rate !== want.linear_rate)
        report_mismatch("linear_rate", 32'(got.linear_rate), 32'(want.linear_rate));
      if (got.stopped !== want.stopped)
        report_mismatch("stopped", 32'(got.stopped), 32'(want.stopped));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg_q.angle_coef       = lss_pkg::RST_ANGLE_COEF;
      cfg_q.forward_speed    = lss_pkg::RST_FWD_SPEED;
      cfg_q.samples_per_scan = lss_pkg::RST_SAMPLES;
      cfg_q.valid_floor_mm   = lss_pkg::RST_VALID_FLOOR;
      cfg_q.stop_distance_mm = lss_pkg::RST_STOP_DIST;
      clear_scan();
      steer_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) write_reg(paddr[4:2], pwdata);
      if (sample_valid && sample_ready) take_sample(sample);
      if (cmd_valid && cmd_ready) check_cmd(cmd);
    end
    due_count <= steer_due.size();
  end

endmodule

### sim/tb_lidar_sector_steering.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lidar_sector_steering: testbench top for the lidar sector steering block
// drives config writes and scans of range samples, with random gaps on the
// sample side and random stalls on the command side; a checker module beside
// the block predicts every steering command and counts mismatches
// ----------------------------------------------------------------------------
module tb_lidar_sector_steering;

  localparam int SCAN_CAP    = 4096;
  localparam int ITEM_TARGET = 1900;

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             sample_valid = 1'b0;
  logic             sample_ready;
  lss_pkg::sample_t sample       = '0;
  logic             cmd_valid;
  logic             cmd_ready    = 1'b0;
  lss_pkg::steer_t  cmd;
  logic             psel         = 1'b0;
  logic             penable      = 1'b0;
  logic             pwrite       = 1'b0;
  logic [4:0]       paddr        = '0;
  logic [31:0]      pwdata       = '0;
  logic [31:0]      prdata;
  logic             pready;
  int               mismatches;
  int               pending;

  // config as last written, used to aim the stimulus
  lss_pkg::cfg_t cur_cfg;
  int unsigned   items_sent = 0;
  // set during the stretch with no idling on either side
  bit            calm = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  lidar_sector_steering #(.MAX_SAMPLES(SCAN_CAP)) i_dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  lss_steer_check #(.MAX_SAMPLES(SCAN_CAP)) i_check (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatches(mismatches), .pending(pending)
  );

  // command side stalls at random, about 21 percent of the time, never while calm
  always @(posedge clk) begin
    cmd_ready <= calm || ($urandom_range(99) >= 21);
  end

  // one apb write: setup phase, then access phase; psel stays up so that
  // back-to-back writes follow directly, the caller drops it at the end
  task automatic apb_write(input logic [2:0] reg_idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  // writes all five registers, so each one gets touched in every phase
  task automatic set_config(input lss_pkg::cfg_t c);
    apb_write(lss_pkg::REG_ANGLE_COEF, {16'h0, c.angle_coef});
    apb_write(lss_pkg::REG_FORWARD_SPEED, {16'h0, c.forward_speed});
    apb_write(lss_pkg::REG_SAMPLES, {19'h0, c.samples_per_scan});
    apb_write(lss_pkg::REG_VALID_FLOOR, {16'h0, c.valid_floor_mm});
    apb_write(lss_pkg::REG_STOP_DIST, {16'h0, c.stop_distance_mm});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_cfg = c;
  endtask

  function automatic lss_pkg::cfg_t cfg_of(input logic [15:0] coef,
                                           input logic [15:0] speed,
                                           input logic [12:0] n,
                                           input logic [15:0] floor_mm,
                                           input logic [15:0] stop_mm);
    lss_pkg::cfg_t c;
    c.angle_coef       = coef;
    c.forward_speed    = speed;
    c.samples_per_scan = n;
    c.valid_floor_mm   = floor_mm;
    c.stop_distance_mm = stop_mm;
    return c;
  endfunction

  // one sample transaction; random gaps before valid goes up, valid held
  // high with the payload steady until the block takes it
  task automatic send_sample(input logic [15:0] rng_mm, input logic [11:0] idx,
                             input logic last);
    calm = (items_sent >= 900 && items_sent < 1250);
    while (!calm && $urandom_range(99) < 21) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= '{range_mm: rng_mm, sample_index: idx, last_sample: last};
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    items_sent++;
  endtask

  // wait until every command has come back and the block has settled
  task automatic drain();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // ranges cluster around the floor and the stop distance, with extremes
  function automatic logic [15:0] pick_range();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return 16'($urandom);
    if (roll < 14) return 16'd0;
    if (roll < 18) return lss_pkg::RANGE_MAX;
    if (roll < 28) return cur_cfg.valid_floor_mm + 16'($urandom_range(2)) - 16'd1;
    if (roll < 36) return cur_cfg.stop_distance_mm + 16'($urandom_range(2)) - 16'd1;
    return cur_cfg.valid_floor_mm + 16'($urandom_range(1, 3000));
  endfunction

  // seed indexes, the front sector, in-scan indexes and some stray ones
  function automatic logic [11:0] pick_index(input int unsigned n);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return 12'd0;
    if (roll < 20) return 12'(n / 2);
    if (roll < 25) return 12'($urandom);
    if (roll < 40 && n >= 360)
      return 12'($urandom_range((n / 360) * 150, (n / 360) * 210 - 1));
    return 12'($urandom_range(0, n - 1));
  endfunction

  // a scan: random subset of indexes, last mark on the final sample
  task automatic send_scan(input int unsigned count);
    int unsigned n;
    n = (cur_cfg.samples_per_scan > SCAN_CAP) ? SCAN_CAP : cur_cfg.samples_per_scan;
    for (int unsigned k = 0; k < count; k++)
      send_sample(pick_range(), pick_index(n), k == count - 1);
  endtask

  function automatic lss_pkg::cfg_t random_config();
    lss_pkg::cfg_t c;
    int unsigned   roll;
    roll = $urandom_range(99);
    c.angle_coef = (roll < 10) ? 16'd0 : (roll < 20) ? 16'hFFFF
                                       : 16'($urandom_range(1, 2048));
    roll = $urandom_range(99);
    c.forward_speed = (roll < 10) ? 16'h8000 : (roll < 20) ? 16'h7FFF : 16'($urandom);
    roll = $urandom_range(99);
    if (roll < 10)      c.samples_per_scan = 13'd8;
    else if (roll < 15) c.samples_per_scan = 13'd8191;
    else if (roll < 20) c.samples_per_scan = 13'd4096;
    else if (roll < 35) c.samples_per_scan = 13'd360;
    else if (roll < 45) c.samples_per_scan = 13'd720;
    else                c.samples_per_scan = 13'($urandom_range(8, 64));
    roll = $urandom_range(99);
    c.valid_floor_mm = (roll < 10) ? 16'd0 : (roll < 15) ? 16'hFFFF
                                           : 16'($urandom_range(0, 200));
    roll = $urandom_range(99);
    c.stop_distance_mm = (roll < 10) ? 16'd0 : (roll < 15) ? 16'hFFFF
                                             : 16'($urandom_range(0, 600));
    return c;
  endfunction

  initial begin
    int unsigned phase_end;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // --- directed part ---
    set_config(cfg_of(16'd256, 16'd1000, 13'd360, 16'd50, 16'd400));
    // stray index at the top of the field, nothing else seen: all sides
    // missing, equal sides give no turn
    send_sample(16'hFFFF, 12'd4095, 1'b1);
    // regular scan: right nearer, below-floor sample in the right sector
    send_sample(16'd2000, 12'd0, 1'b0);
    send_sample(16'd600, 12'd100, 1'b0);
    send_sample(16'd30, 12'd170, 1'b0);
    send_sample(16'd1000, 12'd180, 1'b0);
    send_sample(16'd3000, 12'd200, 1'b1);
    // front obstacle closer than the stop distance
    send_sample(16'd100, 12'd0, 1'b1);
    drain();

    // zero divisor both ways, then both sides zero
    set_config(cfg_of(16'hFFFF, 16'd1000, 13'd360, 16'd50, 16'd0));
    send_sample(16'd0, 12'd0, 1'b0);
    send_sample(16'd500, 12'd180, 1'b1);
    send_sample(16'd0, 12'd180, 1'b0);
    send_sample(16'd700, 12'd0, 1'b1);
    send_sample(16'd0, 12'd0, 1'b0);
    send_sample(16'd0, 12'd180, 1'b1);
    drain();

    // smallest scan: empty front sector, floor at zero
    set_config(cfg_of(16'd512, 16'h8000, 13'd8, 16'd0, 16'd4));
    send_sample(16'd40, 12'd0, 1'b0);
    send_sample(16'd10, 12'd2, 1'b0);
    send_sample(16'd20, 12'd4, 1'b0);
    send_sample(16'd5, 12'd6, 1'b0);
    send_sample(16'd7, 12'd3, 1'b1);
    drain();

    // oversized scan length is clamped; floor at maximum makes all invalid
    set_config(cfg_of(16'd0, 16'h7FFF, 13'd8191, 16'hFFFF, 16'd100));
    send_sample(16'd300, 12'd2048, 1'b0);
    send_sample(16'd200, 12'd0, 1'b0);
    send_sample(16'd9, 12'd1700, 1'b1);

    // --- random part: config phases, each with a run of scans ---
    while (items_sent < ITEM_TARGET) begin
      drain();
      set_config(random_config());
      phase_end = items_sent + $urandom_range(120, 220);
      if (phase_end > ITEM_TARGET) phase_end = ITEM_TARGET;
      while (items_sent < phase_end)
        send_scan(($urandom_range(99) < 10) ? $urandom_range(25, 80)
                                            : $urandom_range(1, 24));
    end

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("PASS lidar_sector_steering");
    end else begin
      $display("FAIL lidar_sector_steering");
    end
    $finish;
  end

  // safety net far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("FAIL lidar_sector_steering");
    $finish;
  end

endmodule
